/* rtl/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the life generation step block
// Item layouts, command codes, register indexes and rule constants.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int DATA_W       = 64;  // row word width on the ports
  localparam int IDX_W        = 6;   // row index width on the ports
  localparam int CFG_W        = 7;   // configuration register width
  localparam int CFG_IDX_W    = 1;   // configuration register index width
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_STEP = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE = 1'b0,
    REG_COLS_IN_USE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  row_index;
    logic [DATA_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  read_row;
    logic [DATA_W-1:0] cell_bits;
  } out_item_t;

  // per-row cell control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

/* rtl/life_generation_step.sv */
// ----------------------------------------------------------------------------
// life_generation_step: Game of Life (B3/S23) board engine
// Row chain board with a load, a one-generation step and a row read command.
// ----------------------------------------------------------------------------
// Usage: present an item on item_i with start high while busy is low. A load
// (mode 0) writes one row in the accept cycle and busy stays low. A read
// (mode 2) puts its result on result_o with result_strobe_o high for exactly
// one cycle, the cycle after the accept; the receiver cannot stall, so take
// it then. A generation step (mode 1) holds busy high after the accept while
// the board, a chain of MAX_ROWS row cells, rotates once, one row per cycle,
// past a single rule unit that sees a three-row window. Mode 3 is a no-op.
// Write rows_in_use / cols_in_use only while idle. The board clears at reset.
// ----------------------------------------------------------------------------
module life_generation_step #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  lgs_pkg::in_item_t                  item_i,
  output logic                               result_strobe_o,
  output lgs_pkg::out_item_t                 result_o,
  input  logic                               cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]          cfg_data_i
);
  import lgs_pkg::*;

  // step counter indexes the rotation, RW compares row counts
  localparam int T_W   = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int RW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RD_N  = (MAX_ROWS < (1 << IDX_W)) ? MAX_ROWS : (1 << IDX_W);
  localparam logic [T_W-1:0] T_LAST = T_W'(MAX_ROWS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(64);
      cols_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROWS_IN_USE: rows_q <= cfg_data_i;
        REG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active region, saturated into 1..MAX
  logic [RW-1:0]       act_rows;
  logic [CFG_W-1:0]    act_cols;
  logic [MAX_COLS-1:0] col_mask;

  always_comb begin
    act_rows = (rows_q == '0) ? RW'(1) : RW'(rows_q);
    if (act_rows > RW'(MAX_ROWS)) act_rows = RW'(MAX_ROWS);
    act_cols = (cols_q == '0) ? CFG_W'(1) : cols_q;
    if (act_cols > CFG_W'(MAX_COLS)) act_cols = CFG_W'(MAX_COLS);
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = CFG_W'(c) < act_cols;
    end
  end

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  logic accept;
  logic is_load, is_step, is_read;

  assign accept  = start && !busy;
  assign is_load = accept && (mode_e'(item_i.mode) == MODE_LOAD);
  assign is_step = accept && (mode_e'(item_i.mode) == MODE_STEP);
  assign is_read = accept && (mode_e'(item_i.mode) == MODE_READ);

  // --------------------------------------------------------------------------
  // Step sequencer: t counts rotation cycles, row t sits at the chain head
  // --------------------------------------------------------------------------
  logic           busy_q, busy_d;
  logic [T_W-1:0] t_q, t_d;

  always_comb begin
    busy_d = busy_q;
    t_d    = t_q;
    if (busy_q) begin
      t_d = t_q + T_W'(1);
      if (t_q == T_LAST) busy_d = 1'b0;
    end else if (is_step) begin
      busy_d = 1'b1;
      t_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      t_q    <= '0;
    end else begin
      busy_q <= busy_d;
      t_q    <= t_d;
    end
  end

  assign busy = busy_q;

  // --------------------------------------------------------------------------
  // Row chain: cell k hands its row to cell k-1 on each step cycle,
  // the last cell takes the freshly computed row.
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] row_w [MAX_ROWS];
  logic [MAX_COLS-1:0] new_row;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic [MAX_COLS-1:0] next_bits;

    assign ctrl.shift = busy_q;
    if (k < (1 << IDX_W)) begin : g_ld
      assign ctrl.load = is_load && (item_i.row_index == IDX_W'(k));
    end else begin : g_nold
      assign ctrl.load = 1'b0;
    end

    if (k == MAX_ROWS - 1) begin : g_tail
      assign next_bits = new_row;
    end else begin : g_link
      assign next_bits = row_w[k+1];
    end

    lgs_row_cell #(
      .MAX_COLS(MAX_COLS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_bits_i(item_i.row_bits[MAX_COLS-1:0]),
      .next_bits_i(next_bits),
      .row_o      (row_w[k])
    );
  end

  // --------------------------------------------------------------------------
  // Three-row window: up from last cycle's head, mid at head, down behind it
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] up_q;
  logic [MAX_COLS-1:0] win_up, win_mid, win_down, rule_row;
  logic                row_live, down_live;

  assign row_live  = RW'(t_q) < act_rows;
  assign down_live = (RW'(t_q) + RW'(1)) < act_rows;
  assign win_up    = (t_q == '0) ? '0 : up_q;
  assign win_mid   = row_w[0] & col_mask;
  assign win_down  = down_live ? (row_w[1] & col_mask) : '0;

  always_ff @(posedge clk_i) begin
    if (busy_q) up_q <= row_w[0] & col_mask;
  end

  lgs_rule_unit #(
    .MAX_COLS(MAX_COLS)
  ) u_rule (
    .up_i      (win_up),
    .mid_i     (win_mid),
    .down_i    (win_down),
    .col_mask_i(col_mask),
    .row_o     (rule_row)
  );

  // rows past the active region die
  assign new_row = row_live ? rule_row : '0;

  // --------------------------------------------------------------------------
  // Row read, registered; strobe in the cycle after the accept
  // --------------------------------------------------------------------------
  logic [MAX_COLS-1:0] rd_row;
  logic                strobe_q;
  out_item_t           result_q;

  always_comb begin
    rd_row = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (item_i.row_index == IDX_W'(k)) rd_row = row_w[k];
    end
    if (!(RW'(item_i.row_index) < act_rows)) rd_row = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      result_q.read_row  <= item_i.row_index;
      result_q.cell_bits <= DATA_W'(rd_row & col_mask);
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

/* rtl/lgs_row_cell.sv */
// ----------------------------------------------------------------------------
// lgs_row_cell: one board row of the cell chain
// Holds a row of cells; loads it or takes its neighbor's row on a shift.
// ----------------------------------------------------------------------------
module lgs_row_cell #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lgs_pkg::cell_ctrl_t ctrl_i,
  input  logic [MAX_COLS-1:0] load_bits_i,
  input  logic [MAX_COLS-1:0] next_bits_i,
  output logic [MAX_COLS-1:0] row_o
);
  import lgs_pkg::*;

  logic [MAX_COLS-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = next_bits_i;
    end else if (ctrl_i.load) begin
      row_d = load_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

/* rtl/lgs_rule_unit.sv */
// ----------------------------------------------------------------------------
// lgs_rule_unit: B3/S23 update of one row
// Counts the eight neighbors of each column from a three-row window.
// ----------------------------------------------------------------------------
module lgs_rule_unit #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic [MAX_COLS-1:0] up_i,
  input  logic [MAX_COLS-1:0] mid_i,
  input  logic [MAX_COLS-1:0] down_i,
  input  logic [MAX_COLS-1:0] col_mask_i,
  output logic [MAX_COLS-1:0] row_o
);
  import lgs_pkg::*;

  // one dead column padded at each side
  logic [MAX_COLS+1:0] up_x, mid_x, down_x;

  assign up_x   = {1'b0, up_i, 1'b0};
  assign mid_x  = {1'b0, mid_i, 1'b0};
  assign down_x = {1'b0, down_i, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
        + 4'(mid_x[c]) + 4'(mid_x[c+2])
        + 4'(down_x[c]) + 4'(down_x[c+1]) + 4'(down_x[c+2]);
      row_o[c] = col_mask_i[c] & ((n == BIRTH_CNT) | (mid_i[c] & (n == SURVIVE_CNT)));
    end
  end

endmodule
